@@ rtl/btf_pkg.sv @@
// Package for the bracket issue tag finder: widths, phase codes, character
// constants, the result type and character-class helpers. No dependencies.
package btf_pkg;

  localparam int unsigned PosW      = 16;
  localparam int unsigned MaxKey    = 256;
  localparam int unsigned KeyCntW   = $clog2(MaxKey) + 1;
  localparam int unsigned ValW      = 64;
  localparam int unsigned TagMinLen = 5;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned ResW      = 1 + 4 * PosW + ValW;
  localparam int unsigned OutDataW  = ((ResW + 7) / 8) * 8;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_BRACKET = 3'd1;
  localparam logic [2:0] PH_KEY     = 3'd2;
  localparam logic [2:0] PH_DIGITS  = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef struct packed {
    logic [ValW-1:0] issue_value;
    logic [PosW-1:0] tag_end_offset;
    logic [PosW-1:0] key_end_offset;
    logic [PosW-1:0] key_offset;
    logic [PosW-1:0] tag_offset;
    logic            found;
  } btf_result_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    return is_digit(b) || ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

endpackage

@@ rtl/btf_matcher.sv @@
// Per-byte tag matcher: scan state registers and the next-state logic.
// Depends on btf_pkg.
module btf_matcher (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [7:0]              byte_i,
  input  logic                    fin_i,
  input  logic [btf_pkg::PosW-1:0] max_dist_i,
  output logic                    res_valid_o,
  output btf_pkg::btf_result_t    res_o
);
  import btf_pkg::*;

  logic [2:0]         phase_q, phase_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [PosW-1:0]    start_q, start_d;
  logic [PosW-1:0]    key_start_q, key_start_d;
  logic [PosW-1:0]    key_end_q, key_end_d;
  logic [KeyCntW-1:0] key_cnt_q, key_cnt_d;
  logic [ValW-1:0]    acc_q, acc_d;
  logic               sat_q, sat_d;
  logic               dig_seen_q, dig_seen_d;

  logic [ValW+3:0] prod;
  logic [PosW:0]   dist_need;

  // acc * 10 + digit; any bit at or above ValW means overflow
  assign prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
              + {{(ValW){1'b0}}, byte_i[3:0]};
  assign dist_need = {1'b0, pos_q} + (PosW+1)'(TagMinLen);

  always_comb begin
    logic [2:0] ph;
    logic       chk;
    logic       hit;
    logic       was_done;
    phase_d     = phase_q;
    pos_d       = pos_q;
    start_d     = start_q;
    key_start_d = key_start_q;
    key_end_d   = key_end_q;
    key_cnt_d   = key_cnt_q;
    acc_d       = acc_q;
    sat_d       = sat_q;
    dig_seen_d  = dig_seen_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    ph          = phase_q;
    chk         = 1'b0;
    hit         = 1'b0;
    was_done    = (phase_q == PH_DONE);
    if (step_i) begin
      if (!was_done) begin
        unique case (phase_q)
          PH_BRACKET: begin
            if (is_alnum(byte_i)) begin
              key_start_d = pos_q;
              key_cnt_d   = '0;
              ph          = PH_KEY;
            end else begin
              ph  = PH_IDLE;
              chk = 1'b1;
            end
          end
          PH_KEY: begin
            if (is_alnum(byte_i)) begin
              key_cnt_d = key_cnt_q + 1'b1;
              if (key_cnt_q >= KeyCntW'(MaxKey - 1)) ph = PH_IDLE;
            end else if (byte_i == CH_DASH) begin
              key_end_d  = pos_q;
              acc_d      = '0;
              sat_d      = 1'b0;
              dig_seen_d = 1'b0;
              ph         = PH_DIGITS;
            end else begin
              ph  = PH_IDLE;
              chk = 1'b1;
            end
          end
          PH_DIGITS: begin
            if (is_digit(byte_i)) begin
              dig_seen_d = 1'b1;
              if (sat_q || (prod[ValW+3:ValW] != 4'd0)) begin
                sat_d = 1'b1;
                acc_d = '1;
              end else begin
                acc_d = prod[ValW-1:0];
              end
            end else if (byte_i == CH_CLOSE) begin
              ph = PH_IDLE;
              if (!((key_cnt_q == '0) && !dig_seen_q) || !fin_i) hit = 1'b1;
            end else begin
              ph  = PH_IDLE;
              chk = 1'b1;
            end
          end
          PH_IDLE: chk = 1'b1;
          default: chk = 1'b0;
        endcase
        if (chk && (byte_i == CH_OPEN) &&
            ((max_dist_i == '0) || (dist_need <= {1'b0, max_dist_i}))) begin
          start_d = pos_q;
          ph      = PH_BRACKET;
        end
        phase_d = hit ? PH_DONE : ph;
        if (hit) begin
          res_valid_o          = 1'b1;
          res_o.found          = 1'b1;
          res_o.tag_offset     = start_q;
          res_o.key_offset     = key_start_q;
          res_o.key_end_offset = key_end_q;
          res_o.tag_end_offset = pos_q + 1'b1;
          res_o.issue_value    = acc_q;
        end
      end
      if (fin_i) begin
        if (!was_done && !hit) res_valid_o = 1'b1;
        phase_d     = PH_IDLE;
        pos_d       = '0;
        start_d     = '0;
        key_start_d = '0;
        key_end_d   = '0;
        key_cnt_d   = '0;
        acc_d       = '0;
        sat_d       = 1'b0;
        dig_seen_d  = 1'b0;
      end else if (pos_q != '1) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      pos_q       <= '0;
      start_q     <= '0;
      key_start_q <= '0;
      key_end_q   <= '0;
      key_cnt_q   <= '0;
      acc_q       <= '0;
      sat_q       <= 1'b0;
      dig_seen_q  <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      start_q     <= start_d;
      key_start_q <= key_start_d;
      key_end_q   <= key_end_d;
      key_cnt_q   <= key_cnt_d;
      acc_q       <= acc_d;
      sat_q       <= sat_d;
      dig_seen_q  <= dig_seen_d;
    end
  end

endmodule

@@ rtl/btf_out_reg.sv @@
// Output register for result words with stream handshake.
// Depends on btf_pkg.
module btf_out_reg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  btf_pkg::btf_result_t              res_i,
  output logic                              free_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [btf_pkg::OutDataW-1:0]      m_axis_tdata
);
  import btf_pkg::*;

  logic        valid_q, valid_d;
  btf_result_t data_q;

  assign free_o  = !valid_q || m_axis_tready;
  assign valid_d = load_i ? 1'b1 : (m_axis_tready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {{(OutDataW - ResW){1'b0}}, data_q};

endmodule

@@ rtl/bracket_issue_tag_finder.sv @@
// Top level of the bracket issue tag finder: config register, matcher and
// output register. Depends on btf_pkg, btf_matcher and btf_out_reg.
//
// Usage: text bytes enter on the s_axis channel, one byte per word, with
// tlast on the last byte of a text. The block reports the first tag of the
// form [KEY-DIGITS] as one word on m_axis, or one not-found word (all zero)
// on the last byte if no tag was seen. Bytes after a match only advance to
// the end of the text. cfg_we_i/cfg_wdata_i write max_start_distance; write
// it only while the block is idle.
// Latency: a result word is valid the cycle after the byte that completes
// it is accepted. Throughput: one byte per cycle while s_axis_tready is high;
// the matcher updates its scan state on every accepted byte.
// Reset: scan state clears to the start of a new text, no result pending,
// max_start_distance = 0 (no limit).
// Stall: while a result waits and m_axis_tready is low, s_axis_tready drops;
// otherwise input flows on even while a result is being taken.
module bracket_issue_tag_finder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [btf_pkg::PosW-1:0]        cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [btf_pkg::InDataW-1:0]     s_axis_tdata,  // [7:0] text_byte
  input  logic                            s_axis_tlast,  // final_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] found, [16:1] tag_offset, [32:17] key_offset, [48:33] key_end_offset,
  // [64:49] tag_end_offset, [128:65] issue_value, [135:129] zero
  output logic [btf_pkg::OutDataW-1:0]    m_axis_tdata
);
  import btf_pkg::*;

  logic [PosW-1:0] max_dist_q;
  logic            free;
  logic            step;
  logic            res_valid;
  btf_result_t     res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= '0;
    end else if (cfg_we_i) begin
      max_dist_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = free;
  assign step          = s_axis_tvalid && free;

  btf_matcher u_matcher (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (s_axis_tdata),
    .fin_i       (s_axis_tlast),
    .max_dist_i  (max_dist_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  btf_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (res_valid),
    .res_i         (res),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

@@ test/bracket_issue_tag_finder_tb.sv @@
// Testbench for bracket_issue_tag_finder: streams texts byte by byte and checks
// each result word against a cycle-free model of the tag search kept in a class.
// Depends on btf_pkg and the bracket_issue_tag_finder RTL.
module bracket_issue_tag_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import btf_pkg::*;

  localparam int unsigned CycleLimit = 1_500_000;

  class tag_search_model;
    btf_result_t pending_tags[$];
    int          mismatches;
    logic [15:0] start_limit;
    logic [2:0]  phase;
    logic [15:0] byte_pos, open_pos, key_pos, key_end;
    int          key_len;
    logic [63:0] value;
    bit          value_sat, got_digit;

    function new();
      mismatches  = 0;
      start_limit = '0;
      clear_text();
    endfunction

    function void clear_text();
      phase     = PH_IDLE;
      byte_pos  = '0;
      open_pos  = '0;
      key_pos   = '0;
      key_end   = '0;
      key_len   = 0;
      value     = '0;
      value_sat = 1'b0;
      got_digit = 1'b0;
    endfunction

    function void set_limit(logic [15:0] v);
      start_limit = v;
    endfunction

    function bit dec_char(logic [7:0] b);
      return b inside {[8'h30 : 8'h39]};
    endfunction

    // letters fold to lower case with bit 5
    function bit key_char(logic [7:0] b);
      logic [7:0] low;
      low = b | 8'h20;
      return dec_char(b) || (low >= 8'h61 && low <= 8'h7A);
    endfunction

    function void take_byte(logic [7:0] b, logic fin);
      logic [15:0] p;
      logic [15:0] end_pos;
      logic [63:0] d;
      bit          was_done, hit, try_open;
      btf_result_t r;
      p        = byte_pos;
      was_done = (phase == PH_DONE);
      hit      = 1'b0;
      try_open = 1'b1;
      end_pos  = '0;
      r        = '0;
      if (!was_done) begin
        case (phase)
          PH_BRACKET: begin
            if (key_char(b)) begin
              key_pos  = p;
              key_len  = 0;
              phase    = PH_KEY;
              try_open = 1'b0;
            end else begin
              phase = PH_IDLE;
            end
          end
          PH_KEY: begin
            if (key_char(b)) begin
              key_len++;
              if (key_len > MaxKey - 1) phase = PH_IDLE;
              try_open = 1'b0;
            end else if (b == CH_DASH) begin
              key_end   = p;
              value     = '0;
              value_sat = 1'b0;
              got_digit = 1'b0;
              phase     = PH_DIGITS;
              try_open  = 1'b0;
            end else begin
              phase = PH_IDLE;
            end
          end
          PH_DIGITS: begin
            if (dec_char(b)) begin
              d         = 64'(b - CH_ZERO);
              got_digit = 1'b1;
              if (value_sat || value > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10) begin
                value_sat = 1'b1;
                value     = '1;
              end else begin
                value = value * 10 + d;
              end
              try_open = 1'b0;
            end else if (b == CH_CLOSE) begin
              phase    = PH_IDLE;
              try_open = 1'b0;
              // a one-char key with no digits needs a byte after the bracket
              if (!(key_len == 0 && !got_digit) || !fin) begin
                hit     = 1'b1;
                end_pos = p + 16'd1;
              end
            end else begin
              phase = PH_IDLE;
            end
          end
          default: ;
        endcase
        if (try_open && phase == PH_IDLE && b == CH_OPEN &&
            (start_limit == 0 || int'(p) + TagMinLen <= int'(start_limit))) begin
          open_pos = p;
          phase    = PH_BRACKET;
        end
        if (hit) begin
          r.found          = 1'b1;
          r.tag_offset     = open_pos;
          r.key_offset     = key_pos;
          r.key_end_offset = key_end;
          r.tag_end_offset = end_pos;
          r.issue_value    = value;
          pending_tags.push_back(r);
          phase = PH_DONE;
        end
      end
      if (fin) begin
        if (!was_done && !hit) pending_tags.push_back('0);
        clear_text();
      end else if (byte_pos != 16'hFFFF) begin
        byte_pos = byte_pos + 16'd1;
      end
    endfunction

    function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [OutDataW-1:0] w);
      btf_result_t got, want;
      got = w[ResW-1:0];
      if (pending_tags.size() == 0) begin
        $display("%0t unexpected result word: expected none, got %h", $time, w);
        mismatches++;
        return;
      end
      want = pending_tags.pop_front();
      cmp_field("found", 64'(want.found), 64'(got.found));
      cmp_field("tag_offset", 64'(want.tag_offset), 64'(got.tag_offset));
      cmp_field("key_offset", 64'(want.key_offset), 64'(got.key_offset));
      cmp_field("key_end_offset", 64'(want.key_end_offset), 64'(got.key_end_offset));
      cmp_field("tag_end_offset", 64'(want.tag_end_offset), 64'(got.tag_end_offset));
      cmp_field("issue_value", want.issue_value, got.issue_value);
      cmp_field("pad", 64'd0, 64'(w[OutDataW-1:ResW]));
    endfunction

    function int pending();
      return pending_tags.size();
    endfunction

    function void flush_check();
      foreach (pending_tags[i]) begin
        $display("%0t missing result: expected %h, got none", $time, pending_tags[i]);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [PosW-1:0]     cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  tag_search_model model = new();
  logic [7:0]      txt[$];
  int              send_idle_pct  = 0;
  int              recv_stall_pct = 0;
  int              hold_req       = 0;
  int              hold_left      = 0;
  int              cycle_count    = 0;

  bracket_issue_tag_finder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) model.check_result(m_axis_tdata);
    if (rst_ni && s_axis_tvalid && s_axis_tready) model.take_byte(s_axis_tdata, s_axis_tlast);
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        hold_left = 400;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [7:0] key_byte();
    case ($urandom_range(2))
      0:       return 8'(CH_ZERO + $urandom_range(9));
      1:       return 8'(8'h41 + $urandom_range(25));
      default: return 8'(8'h61 + $urandom_range(25));
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(7))
      0:       return CH_OPEN;
      1:       return CH_CLOSE;
      2:       return CH_DASH;
      3:       return 8'(CH_ZERO + $urandom_range(9));
      4:       return key_byte();
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endfunction

  function automatic void add_tag(int klen, int dlen);
    txt.push_back(CH_OPEN);
    repeat (klen) txt.push_back(key_byte());
    txt.push_back(CH_DASH);
    repeat (dlen) txt.push_back(8'(CH_ZERO + $urandom_range(9)));
    txt.push_back(CH_CLOSE);
  endfunction

  function automatic void add_key_run(int klen);
    txt.push_back(CH_OPEN);
    repeat (klen) txt.push_back(key_byte());
    add_str("-1]x");
  endfunction

  function automatic void build_random_text();
    int mode;
    int klen, dlen;
    mode = $urandom_range(99);
    if (mode < 65) begin
      repeat ($urandom_range(8)) txt.push_back(noise_byte());
      klen = $urandom_range(1, 6);
      dlen = ($urandom_range(9) == 0) ? $urandom_range(18, 24) : $urandom_range(0, 4);
      if ($urandom_range(9) == 0) begin
        klen = 1;
        dlen = 0;
      end
      add_tag(klen, dlen);
      repeat ($urandom_range(4)) txt.push_back(noise_byte());
      if ($urandom_range(4) == 0) txt[$urandom_range(txt.size() - 1)] = noise_byte();
    end else if (mode < 80) begin
      // first tag with one byte overwritten, then a good tag
      add_tag($urandom_range(1, 4), $urandom_range(0, 3));
      txt[$urandom_range(1, txt.size() - 1)] = $urandom_range(1) ? CH_OPEN : noise_byte();
      add_tag($urandom_range(1, 4), $urandom_range(0, 3));
      repeat ($urandom_range(2)) txt.push_back(noise_byte());
    end else begin
      repeat ($urandom_range(1, 12)) txt.push_back(noise_byte());
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_text();
    foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
    txt.delete();
  endtask

  task automatic send_str(string s);
    add_str(s);
    send_text();
  endtask

  task automatic run_random(int n_bytes);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      build_random_text();
      sent += txt.size();
      send_text();
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (model.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model.set_limit(v);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();

    // directed, no limit on start offset
    write_cfg(16'd0);
    set_idling(0, 0);
    send_str("[A-1]x");
    send_str("[A-]");
    send_str("[A-]x");
    txt.push_back(8'hFF);
    send_text();
    txt.push_back(8'h00);
    send_text();
    send_str("[Zz09-18446744073709551615]");
    send_str("[q-18446744073709551616]");
    send_str("[[A-2]");
    send_str("[z-3]][x-1]");
    send_str("[@-1][`-1][{-1][/-1][:-1]x");
    send_str("[9-/]x");
    add_key_run(256);
    send_text();
    add_key_run(257);
    send_text();

    settle();
    write_cfg(16'hFFFF);
    set_idling(82, 0);
    run_random(30);

    settle();
    write_cfg(16'd12);
    set_idling(0, 82);
    run_random(30);

    settle();
    write_cfg(16'd1);
    set_idling(28, 28);
    run_random(30);

    // receiver holds off while the sender keeps offering
    settle();
    write_cfg(16'd6);
    set_idling(0, 0);
    hold_req = 1;
    run_random(30);

    for (int k = 0; k < 3; k++) begin
      settle();
      write_cfg(16'($urandom_range(5, 40)));
      set_idling(k == 1 ? 82 : 28, k == 2 ? 82 : 28);
      run_random(15);
    end

    settle();
    write_cfg(16'd0);
    set_idling(0, 0);
    run_random(20);

    settle();
    model.flush_check();
    if (model.mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/btf_pkg.sv
rtl/btf_matcher.sv
rtl/btf_out_reg.sv
rtl/bracket_issue_tag_finder.sv
test/bracket_issue_tag_finder_tb.sv
